// ===== rtl/core/sm3_pkg.sv =====
// shared types, constants and round functions for the sm3 hash engine
`timescale 1ns / 1ps
package sm3_pkg;

    localparam logic [31:0] T_EARLY = 32'h79CC4519;
    localparam logic [31:0] T_LATE  = 32'h7A879D8A;
    localparam logic [31:0] PAD_WORD = 32'h80000000;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned N_ROUNDS = 64;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic        load_word;   // write w into buffer slot
        logic [1:0]  word_sel;    // 0 input, 1 zero, 2 len hi, 3 len lo
        logic        add_len;     // add input bit count to length
        logic        start_round; // copy cv to working vars
        logic        do_round;
        logic        finish;      // xor working vars into cv
        logic        reset_msg;   // cv to iv, length and slot to zero
        logic        pad_after;   // write the pad word 0x80000000 instead of the selected word
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       block_full;   // slot at 15 before the write
        logic [3:0] slot;
        logic       last_round;
    } t_stat;

    function automatic t_word iv_word(input logic [2:0] idx);
        t_word v;
        unique case (idx)
            3'd0: v = 32'h7380166F;
            3'd1: v = 32'h4914B2B9;
            3'd2: v = 32'h172442D7;
            3'd3: v = 32'hDA8A0600;
            3'd4: v = 32'hA96F30BC;
            3'd5: v = 32'h163138AA;
            3'd6: v = 32'hE38DEE4D;
            default: v = 32'hB0FB0E4E;
        endcase
        return v;
    endfunction

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic t_word p0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word p1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ===== rtl/core/sm3_ctrl.sv =====
// controller state machine for the sm3 hash engine
`timescale 1ns / 1ps
module sm3_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  sm3_pkg::t_in_req i_in_req,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_out_index,
    input  sm3_pkg::t_stat  i_stat,
    output sm3_pkg::t_cmd   o_cmd
);
    import sm3_pkg::*;

    t_state r_state, n_state;
    logic   r_fin, n_fin;       // message ended, pad/emit after block
    logic   r_extra, n_extra;   // pad word 0x80 still owed
    logic   r_len_lo, n_len_lo; // length high word just written
    logic   r_emit_pend, n_emit_pend;
    logic [2:0] r_idx, n_idx;
    logic   acc, is_last;

    assign acc     = i_in_valid && !o_in_stall;
    assign is_last = i_in_req.last_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fin    <= 1'b0;
            r_extra  <= 1'b0;
            r_len_lo <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_fin    <= n_fin;
            r_extra  <= n_extra;
            r_len_lo <= n_len_lo;
            r_idx    <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_fin    = r_fin;
        n_extra  = r_extra;
        n_len_lo = (r_state == ST_PAD) && !r_extra && (i_stat.slot == 4'd14);
        n_idx    = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_fin   = is_last;
                    n_extra = is_last && (i_in_req.valid_bytes >= 3'd4);
                    if (i_stat.block_full) n_state = ST_ROUND;
                    else if (is_last) n_state = ST_PAD;
                end
            end
            ST_ROUND: begin
                if (i_stat.last_round) n_state = r_fin ? ST_PAD : ST_IDLE;
            end
            ST_PAD: begin
                n_extra = 1'b0;
                if (i_stat.block_full) n_state = ST_ROUND;
                if (r_len_lo) n_fin = 1'b0;
            end
            ST_EMIT: begin
                if (!i_out_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // after the length block, emit
        if (r_state == ST_ROUND && i_stat.last_round && !r_fin && r_emit_pend)
            n_state = ST_EMIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_emit_pend <= 1'b0;
        else          r_emit_pend <= n_emit_pend;
    end
    always_comb begin
        n_emit_pend = r_emit_pend;
        if (r_state == ST_PAD && r_len_lo) n_emit_pend = 1'b1;
        if (r_state == ST_EMIT) n_emit_pend = 1'b0;
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_out_index = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (acc) begin
                    o_cmd.load_word = !(is_last && i_in_req.valid_bytes == 3'd0) ||
                                      1'b1;
                    o_cmd.word_sel  = 2'd0;
                    o_cmd.add_len   = 1'b1;
                    o_cmd.pad_after = 1'b0;
                    o_cmd.start_round = i_stat.block_full;
                end
            end
            ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                o_cmd.finish   = i_stat.last_round;
            end
            ST_PAD: begin
                o_cmd.load_word = 1'b1;
                if (r_extra) o_cmd.pad_after = 1'b1;
                else if (i_stat.slot == 4'd14) o_cmd.word_sel = 2'd2;
                else if (r_len_lo) o_cmd.word_sel = 2'd3;
                else o_cmd.word_sel = 2'd1;
                o_cmd.start_round = i_stat.block_full;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.reset_msg = !i_out_stall && r_idx == 3'd7;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/core/sm3_dp.sv =====
// datapath for the sm3 hash engine: block buffer, expansion window, round unit
`timescale 1ns / 1ps
module sm3_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sm3_pkg::t_in_req i_in_req,
    input  sm3_pkg::t_cmd   i_cmd,
    input  logic [2:0]      i_out_index,
    output sm3_pkg::t_stat  o_stat,
    output logic [31:0]     o_digest
);
    import sm3_pkg::*;

    t_word r_cv [8];
    t_word r_v [8];
    t_word r_w [16];
    t_word r_blk [16];
    logic [63:0] r_len;
    logic [3:0]  r_slot;
    logic [5:0]  r_rnd;

    t_word in_word, wr_word, w_new, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    logic [31:0] keep;
    logic [2:0]  vb;
    logic        early;

    always_comb begin
        vb = (!i_in_req.last_word || i_in_req.valid_bytes > 3'd4) ? 3'd4
                                                                  : i_in_req.valid_bytes;
        keep = ~(32'hFFFFFFFF >> {vb, 3'b000});
        if (vb == 3'd4) in_word = i_in_req.message_word;
        else in_word = (i_in_req.message_word & keep) |
                       (32'({PAD_BYTE, 24'h0}) >> {vb, 3'b000});
        if (i_cmd.pad_after) wr_word = PAD_WORD;
        else begin
            case (i_cmd.word_sel)
                2'd0: wr_word = in_word;
                2'd1: wr_word = '0;
                2'd2: wr_word = r_len[63:32];
                default: wr_word = r_len[31:0];
            endcase
        end
    end

    assign o_stat.block_full = i_cmd.load_word && r_slot == 4'd15;
    assign o_stat.slot       = r_slot;
    assign o_stat.last_round = r_rnd == 6'd63;
    assign o_digest          = r_cv[i_out_index];

    always_comb begin
        early = r_rnd < 6'd16;
        tj  = rotl(early ? T_EARLY : T_LATE, r_rnd[4:0]);
        a12 = rotl(r_v[0], 5'd12);
        ss1 = rotl(a12 + r_v[4] + tj, 5'd7);
        ss2 = ss1 ^ a12;
        ff  = early ? (r_v[0] ^ r_v[1] ^ r_v[2])
                    : ((r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]));
        gg  = early ? (r_v[4] ^ r_v[5] ^ r_v[6]) : ((r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]));
        tt1 = ff + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_v[7] + ss1 + r_w[0];
        w_new = p1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15)) ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_slot <= '0;
            r_rnd  <= '0;
            for (int i = 0; i < 8; i++) r_cv[i] <= iv_word(3'(i));
        end else begin
            if (i_cmd.load_word) begin
                r_slot <= r_slot + 4'd1;
                if (i_cmd.add_len) r_len <= r_len + 64'({vb, 3'b000});
            end
            if (i_cmd.do_round) r_rnd <= r_rnd + 6'd1;
            // fold in the working vars as they leave the final round
            if (i_cmd.finish) begin
                r_cv[0] <= r_cv[0] ^ tt1;
                r_cv[1] <= r_cv[1] ^ r_v[0];
                r_cv[2] <= r_cv[2] ^ rotl(r_v[1], 5'd9);
                r_cv[3] <= r_cv[3] ^ r_v[2];
                r_cv[4] <= r_cv[4] ^ p0(tt2);
                r_cv[5] <= r_cv[5] ^ r_v[4];
                r_cv[6] <= r_cv[6] ^ rotl(r_v[5], 5'd19);
                r_cv[7] <= r_cv[7] ^ r_v[6];
            end
            if (i_cmd.reset_msg) begin
                r_len  <= '0;
                r_slot <= '0;
                for (int i = 0; i < 8; i++) r_cv[i] <= iv_word(3'(i));
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) r_blk[r_slot] <= wr_word;
        if (i_cmd.start_round) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_cv[i];
            for (int i = 0; i < 15; i++) r_w[i] <= r_blk[i];
            r_w[15] <= wr_word;
        end else if (i_cmd.do_round) begin
            r_v[0] <= tt1;
            r_v[1] <= r_v[0];
            r_v[2] <= rotl(r_v[1], 5'd9);
            r_v[3] <= r_v[2];
            r_v[4] <= p0(tt2);
            r_v[5] <= r_v[4];
            r_v[6] <= rotl(r_v[5], 5'd19);
            r_v[7] <= r_v[6];
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end
endmodule

// ===== rtl/core/sm3_hash_engine_top.sv =====
// top level of the sm3 hash engine
// last word: the padding and length words are written, the final block runs its rounds, then 8 digest words
// throughput: one round per cycle; input is stalled while a block's rounds run
// reset: synchronous active low, chaining value to iv, length and slot cleared
`timescale 1ns / 1ps
module sm3_hash_engine_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  sm3_pkg::t_in_req i_in_req,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sm3_pkg::t_out_req o_out_req
);
    import sm3_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [2:0] idx;
    logic [31:0] dig;

    sm3_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_req, .o_in_stall,
        .o_out_valid, .i_out_stall, .o_out_index(idx), .i_stat(stat), .o_cmd(cmd)
    );

    sm3_dp u_dp (
        .i_clk, .i_rst_n, .i_in_req, .i_cmd(cmd), .i_out_index(idx),
        .o_stat(stat), .o_digest(dig)
    );

    assign o_out_req.digest_word  = dig;
    assign o_out_req.digest_index = idx;
    assign o_out_req.digest_last  = idx == 3'd7;

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && !o_in_stall)) else $error("input open while emitting");
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.do_round && cmd.load_word)) else $error("load during round");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(idx))
        else $error("digest moved while stalled");
endmodule
